>>> hdl/points_to_constraint_step_assert.svh
`ifndef POINTS_TO_CONSTRAINT_STEP_ASSERT_SVH
`define POINTS_TO_CONSTRAINT_STEP_ASSERT_SVH

// same-cycle implication under reset
`define PTC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define PTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ptc_pkg.sv
package ptc_pkg;

   // table geometry
   localparam int NUM_VARS = 64;
   localparam int VAR_W    = 6;
   localparam int ROW_W    = 64;
   localparam int CNT_W    = 16;
   localparam int ROWS     = 1 << VAR_W;

   localparam logic [ROW_W-1:0] ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - NUM_VARS);
   localparam logic [VAR_W-1:0] LAST_IDX = VAR_W'(NUM_VARS - 1);
   localparam logic [CNT_W-1:0] FAIL_MAX = {CNT_W{1'b1}};

   // command and kind codes
   localparam logic       CMD_APPLY = 1'b0;
   localparam logic       CMD_READ  = 1'b1;
   localparam logic [1:0] LHS_PLAIN = 2'd1;
   localparam logic [1:0] LHS_DEREF = 2'd2;
   localparam logic [1:0] RHS_ADDR  = 2'd0;
   localparam logic [1:0] RHS_PLAIN = 2'd1;
   localparam logic [1:0] RHS_DEREF = 2'd2;
   localparam logic [1:0] RHS_BAD   = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_Y,
      S_GET_Y,
      S_SCAN,
      S_SCAN_END,
      S_RD_X,
      S_GET_X,
      S_FIN,
      S_LOAD,
      S_DONE
   } ptc_state_type;

   typedef struct packed {
      logic             command;
      logic [1:0]       lhs_kind;
      logic [1:0]       rhs_kind;
      logic [VAR_W-1:0] lhs_var;
      logic [VAR_W-1:0] rhs_var;
   } ptc_item_type;

   // variable index names an existing row
   function automatic logic var_in_range(logic [VAR_W-1:0] v);
      return int'(v) < NUM_VARS;
   endfunction

   // one-hot pointee bit, empty for a missing variable
   function automatic logic [ROW_W-1:0] var_bit(logic [VAR_W-1:0] v);
      return var_in_range(v) ? (ROW_W'(1) << v) : '0;
   endfunction

endpackage

>>> hdl/ptc_req_if.sv
interface ptc_req_if;
   import ptc_pkg::*;

   logic             valid;
   logic             ready;
   logic             command;
   logic [1:0]       lhs_kind;
   logic [1:0]       rhs_kind;
   logic [VAR_W-1:0] lhs_var;
   logic [VAR_W-1:0] rhs_var;

   modport source (output valid, command, lhs_kind, rhs_kind, lhs_var, rhs_var,
                   input ready);
   modport sink (input valid, command, lhs_kind, rhs_kind, lhs_var, rhs_var,
                 output ready);
endinterface

>>> hdl/ptc_rsp_if.sv
interface ptc_rsp_if;
   import ptc_pkg::*;

   logic             valid;
   logic             ready;
   logic             changed;
   logic             invalid;
   logic [ROW_W-1:0] row_bits;
   logic [CNT_W-1:0] failed_count;

   modport source (output valid, changed, invalid, row_bits, failed_count,
                   input ready);
   modport sink (input valid, changed, invalid, row_bits, failed_count,
                 output ready);
endinterface

>>> hdl/ptc_ram.sv
module ptc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/points_to_constraint_step.sv
// a read item or invalid pair goes straight to S_FIN, S_LOAD and S_DONE; x=&y reads
// row x in S_RD_X and S_GET_X, and x=y first reads row y in S_RD_Y and S_GET_Y
// each dereference is a full sweep of all NUM_VARS rows through the single table RAM
// one item at a time: the next item is taken the cycle after the result is accepted
// each sweep runs S_SCAN over every row and ends in S_SCAN_END
// reset (synchronous, active high) clears every per-row valid bit and the failure counter
`include "points_to_constraint_step_assert.svh"

module points_to_constraint_step (
   input logic          clock,
   input logic          reset,
   ptc_req_if.sink      req_chan,
   ptc_rsp_if.source    rsp_chan
);
   import ptc_pkg::*;

   ptc_state_type    state_ff, state_in;
   ptc_item_type     item_ff, item_in;
   logic [ROW_W-1:0] add_ff, add_in;
   logic [ROW_W-1:0] set_ff, set_in;
   logic [VAR_W-1:0] cnt_ff, cnt_in;
   logic [VAR_W-1:0] pidx_ff, pidx_in;
   logic             pend_ff, pend_in;
   logic             merge_ff, merge_in;
   logic             changed_ff, changed_in;
   logic             bad_ff, bad_in;
   logic [CNT_W-1:0] fail_ff, fail_in;
   logic [ROWS-1:0]  valid_ff, valid_in;
   logic             rd_ok_ff, rd_ok_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic             ram_we;
   logic [VAR_W-1:0] ram_waddr;
   logic [ROW_W-1:0] ram_wdata;
   logic [VAR_W-1:0] ram_raddr;
   logic [ROW_W-1:0] ram_q;
   logic [ROW_W-1:0] rd_data;
   logic [ROW_W-1:0] merged;
   logic             grow;
   logic             accept;
   logic             pair_ok;

   ptc_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_rows (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr   (ram_raddr),
      .rd_data (ram_q)
   );

   // a row never written reads empty
   assign rd_data = rd_ok_ff ? (ram_q & ROW_MASK) : '0;
   assign merged  = (rd_data | add_ff) & ROW_MASK;
   assign grow    = merged != rd_data;

   assign accept  = req_chan.valid && req_chan.ready;
   assign pair_ok = (req_chan.lhs_kind == LHS_PLAIN || req_chan.lhs_kind == LHS_DEREF)
                    && req_chan.rhs_kind != RHS_BAD;

   assign req_chan.ready        = state_ff == S_IDLE;
   assign rsp_chan.valid        = state_ff == S_DONE;
   assign rsp_chan.changed      = changed_ff;
   assign rsp_chan.invalid      = bad_ff;
   assign rsp_chan.row_bits     = out_row_ff;
   assign rsp_chan.failed_count = fail_ff;

   // sequencer and shared row port
   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      add_in     = add_ff;
      set_in     = set_ff;
      cnt_in     = cnt_ff;
      pidx_in    = cnt_ff;
      pend_in    = 1'b0;
      merge_in   = merge_ff;
      changed_in = changed_ff;
      bad_in     = bad_ff;
      fail_in    = fail_ff;
      valid_in   = valid_ff;
      out_row_in = out_row_ff;
      ram_we     = 1'b0;
      ram_waddr  = pidx_ff;
      ram_wdata  = merged;
      ram_raddr  = item_ff.lhs_var;

      // row data from the previous sweep cycle
      if (pend_ff) begin
         if (merge_ff) begin
            ram_we     = 1'b1;
            changed_in = changed_ff | grow;
         end else begin
            add_in = add_ff | rd_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in.command  = req_chan.command;
               item_in.lhs_kind = req_chan.lhs_kind;
               item_in.rhs_kind = req_chan.rhs_kind;
               item_in.lhs_var  = req_chan.lhs_var;
               item_in.rhs_var  = req_chan.rhs_var;
               changed_in       = 1'b0;
               bad_in           = 1'b0;
               add_in           = '0;
               if (req_chan.command == CMD_READ) begin
                  state_in = S_FIN;
               end else if (!pair_ok) begin
                  bad_in   = 1'b1;
                  fail_in  = (fail_ff == FAIL_MAX) ? fail_ff : fail_ff + CNT_W'(1);
                  state_in = S_FIN;
               end else if (req_chan.rhs_kind == RHS_ADDR) begin
                  add_in   = var_bit(req_chan.rhs_var);
                  state_in = S_RD_X;
               end else begin
                  state_in = S_RD_Y;
               end
            end
         end
         S_RD_Y: begin
            ram_raddr = item_ff.rhs_var;
            state_in  = S_GET_Y;
         end
         S_GET_Y: begin
            if (item_ff.rhs_kind == RHS_PLAIN) begin
               add_in   = rd_data;
               state_in = S_RD_X;
            end else begin
               set_in   = rd_data;
               cnt_in   = '0;
               merge_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ram_raddr = cnt_ff;
            pend_in   = set_ff[cnt_ff];
            cnt_in    = cnt_ff + VAR_W'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = merge_ff ? S_FIN : S_RD_X;
         end
         S_RD_X: begin
            state_in = S_GET_X;
         end
         S_GET_X: begin
            if (item_ff.lhs_kind == LHS_PLAIN) begin
               ram_we     = var_in_range(item_ff.lhs_var);
               ram_waddr  = item_ff.lhs_var;
               changed_in = var_in_range(item_ff.lhs_var) && grow;
               state_in   = S_FIN;
            end else begin
               set_in   = rd_data;
               cnt_in   = '0;
               merge_in = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_FIN: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            out_row_in = rd_data;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a written row becomes live
      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   // read qualifier follows the registered read
   assign rd_ok_in = var_in_range(ram_raddr) && valid_ff[ram_raddr];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fail_ff  <= '0;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      add_ff     <= add_in;
      set_ff     <= set_in;
      cnt_ff     <= cnt_in;
      pidx_ff    <= pidx_in;
      merge_ff   <= merge_in;
      changed_ff <= changed_in;
      bad_ff     <= bad_in;
      out_row_ff <= out_row_in;
   end

   // checks
   `PTC_ASSERT_NEXT(a_no_early_rsp, clock, reset, accept, !rsp_chan.valid, "result right after accept")
   `PTC_ASSERT_NOW(a_no_accept_busy, clock, reset, rsp_chan.valid, !req_chan.ready, "ready while result pending")
   `PTC_ASSERT_NOW(a_flag_excl, clock, reset, rsp_chan.valid, !(rsp_chan.changed && rsp_chan.invalid), "changed and invalid together")
   `PTC_ASSERT_NOW(a_fail_mono, clock, reset, !$past(reset), fail_ff >= $past(fail_ff), "failure counter went down")
endmodule

>>> sim/points_to_constraint_step_tb.sv
module points_to_constraint_step_tb;
   import ptc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // left kinds that name no supported form
   localparam logic [1:0] LHS_BAD_LO = 2'd0;
   localparam logic [1:0] LHS_BAD_HI = 2'd3;

   localparam int RANDOM_PER_PHASE = 350;
   localparam int HOLD_CYCLES      = 400;
   localparam int TAIL_CYCLES      = 200;
   localparam int CYCLE_LIMIT      = 3000000;
   localparam int REPORT_CAP       = 100;

   typedef struct packed {
      logic             changed;
      logic             invalid;
      logic [ROW_W-1:0] row_bits;
      logic [CNT_W-1:0] failed_count;
   } step_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptc_req_if req_if ();
   ptc_rsp_if rsp_if ();

   points_to_constraint_step u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predictor state: points-to table and failure counter
   logic [ROW_W-1:0] points_to [ROWS];
   logic [CNT_W-1:0] fail_total;

   ptc_item_type    stim_queue [$];
   step_result_type pending_results [$];
   ptc_item_type    next_item;
   step_result_type want_rsp;

   int          items_queued   = 0;
   int          items_offered  = 0;
   int          items_accepted = 0;
   int          mismatches     = 0;
   int          cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_arm       = 1'b0;
   logic        hold_used      = 1'b0;
   int          hold_left      = 0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // OR gain into row v, ignore rows that do not exist, report growth
   function automatic logic merge_row(logic [VAR_W-1:0] v, logic [ROW_W-1:0] gain);
      logic [ROW_W-1:0] grown;
      if (int'(v) >= NUM_VARS)
         return 1'b0;
      grown = (points_to[v] | gain) & ROW_MASK;
      if (grown == (points_to[v] & ROW_MASK))
         return 1'b0;
      points_to[v] = grown;
      return 1'b1;
   endfunction

   // advance the table by one item and build the result it should give
   function automatic step_result_type apply_item(ptc_item_type it);
      logic [ROW_W-1:0] prior [ROWS];
      logic [ROW_W-1:0] gain;
      logic             well_formed;
      step_result_type  r;
      int               p;
      r = '0;
      gain = '0;
      // snapshot: every source row comes from the table before the item
      for (p = 0; p < ROWS; p++)
         prior[p] = (p < NUM_VARS) ? (points_to[p] & ROW_MASK) : '0;
      if (it.command == CMD_APPLY) begin
         well_formed = (it.lhs_kind == LHS_PLAIN || it.lhs_kind == LHS_DEREF) &&
                       it.rhs_kind != RHS_BAD;
         if (!well_formed) begin
            r.invalid = 1'b1;
            if (fail_total != FAIL_MAX)
               fail_total = fail_total + CNT_W'(1);
         end else begin
            case (it.rhs_kind)
               RHS_ADDR: begin
                  if (int'(it.rhs_var) < NUM_VARS)
                     gain = ROW_W'(1) << it.rhs_var;
               end
               RHS_PLAIN: begin
                  gain = prior[it.rhs_var];
               end
               default: begin
                  for (p = 0; p < ROWS; p++)
                     if (prior[it.rhs_var][p])
                        gain |= prior[p];
               end
            endcase
            if (it.lhs_kind == LHS_PLAIN) begin
               r.changed = merge_row(it.lhs_var, gain);
            end else begin
               // every pointee of x takes the gain, no early exit
               for (p = 0; p < ROWS; p++)
                  if (prior[it.lhs_var][p])
                     if (merge_row(VAR_W'(p), gain))
                        r.changed = 1'b1;
            end
         end
      end
      r.row_bits = (int'(it.lhs_var) < NUM_VARS) ? (points_to[it.lhs_var] & ROW_MASK) : '0;
      r.failed_count = fail_total;
      return r;
   endfunction

   function automatic ptc_item_type cmd_item(logic cmd, logic [1:0] lk, logic [1:0] rk,
                                             int x, int y);
      ptc_item_type it;
      it.command  = cmd;
      it.lhs_kind = lk;
      it.rhs_kind = rk;
      it.lhs_var  = VAR_W'(x);
      it.rhs_var  = VAR_W'(y);
      return it;
   endfunction

   // mostly variables near base so rows build up and dereferences find pointees
   function automatic logic [VAR_W-1:0] pick_var(int unsigned base);
      if ($urandom_range(99) < 80)
         return VAR_W'(base + $urandom_range(11));
      return VAR_W'($urandom_range(63));
   endfunction

   // apply item with an unsupported kind pair
   function automatic ptc_item_type broken_item();
      ptc_item_type it;
      it.command = CMD_APPLY;
      if ($urandom_range(1)) begin
         it.lhs_kind = $urandom_range(1) ? LHS_BAD_HI : LHS_BAD_LO;
         it.rhs_kind = 2'($urandom_range(3));
      end else begin
         it.lhs_kind = $urandom_range(1) ? LHS_DEREF : LHS_PLAIN;
         it.rhs_kind = RHS_BAD;
      end
      it.lhs_var = 6'($urandom_range(63));
      it.rhs_var = 6'($urandom_range(63));
      return it;
   endfunction

   function automatic ptc_item_type random_item(int unsigned base);
      ptc_item_type it;
      int unsigned  roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         it = broken_item();
      end else begin
         it.command  = CMD_APPLY;
         it.lhs_kind = $urandom_range(1) ? LHS_DEREF : LHS_PLAIN;
         case ($urandom_range(2))
            0: it.rhs_kind = RHS_ADDR;
            1: it.rhs_kind = RHS_PLAIN;
            default: it.rhs_kind = RHS_DEREF;
         endcase
      end
      // reads carry junk in the ignored fields
      if (roll >= 88) begin
         it.command  = CMD_READ;
         it.lhs_kind = 2'($urandom_range(3));
         it.rhs_kind = 2'($urandom_range(3));
      end
      it.lhs_var = pick_var(base);
      it.rhs_var = pick_var(base);
      return it;
   endfunction

   task automatic queue_item(ptc_item_type it);
      stim_queue.push_back(it);
      items_queued++;
   endtask

   task automatic queue_random(int count);
      int unsigned base;
      int          n;
      base = 0;
      for (n = 0; n < count; n++) begin
         // move the variable window now and then so fresh rows keep growing
         if (n % 50 == 0)
            base = $urandom_range(52);
         queue_item(random_item(base));
      end
   endtask

   // sender pause: let every item go through and every result come back
   task automatic drain_all();
      do
         @(negedge clock);
      while (items_accepted != items_queued || pending_results.size() != 0);
      @(posedge clock);
   endtask

   task automatic check_field(string name, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         // keep the log readable if something breaks for good
         if (mismatches <= REPORT_CAP)
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   // request driver: holds an item until it is taken, idles at random
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || items_accepted == items_offered) begin
         if (stim_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = stim_queue.pop_front();
            req_if.command  <= next_item.command;
            req_if.lhs_kind <= next_item.lhs_kind;
            req_if.rhs_kind <= next_item.rhs_kind;
            req_if.lhs_var  <= next_item.lhs_var;
            req_if.rhs_var  <= next_item.rhs_var;
            req_if.valid    <= 1'b1;
            items_offered++;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // accepted request item: predict its result
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         pending_results.push_back(apply_item(cmd_item(req_if.command, req_if.lhs_kind,
                                                       req_if.rhs_kind, int'(req_if.lhs_var),
                                                       int'(req_if.rhs_var))));
         items_accepted++;
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_arm && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result ready with random stalls
   always @(negedge clock) begin
      rsp_if.ready <= !reset && hold_left == 0 && ($urandom_range(99) >= recv_stall_pct);
   end

   // result monitor: compare against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $error("result item with none expected");
         end else begin
            want_rsp = pending_results.pop_front();
            check_field("changed", ROW_W'(want_rsp.changed), ROW_W'(rsp_if.changed));
            check_field("invalid", ROW_W'(want_rsp.invalid), ROW_W'(rsp_if.invalid));
            check_field("row_bits", want_rsp.row_bits, rsp_if.row_bits);
            check_field("failed_count", ROW_W'(want_rsp.failed_count),
                        ROW_W'(rsp_if.failed_count));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("no progress after %0d cycles", CYCLE_LIMIT);
         $display("FAIL points_to_constraint_step");
         $finish;
      end
   end

   initial begin
      int p;
      for (p = 0; p < ROWS; p++)
         points_to[p] = '0;
      fail_total = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, each constraint form, invalid pairs, edges
      queue_item(cmd_item(CMD_READ,  LHS_BAD_HI, RHS_BAD,   0,  63));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_ADDR,  0,  0));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_ADDR,  63, 63));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_ADDR,  1,  2));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_ADDR,  1,  2));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_ADDR,  2,  63));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_PLAIN, 3,  1));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_DEREF, 4,  3));
      queue_item(cmd_item(CMD_APPLY, LHS_DEREF,  RHS_ADDR,  1,  5));
      queue_item(cmd_item(CMD_APPLY, LHS_DEREF,  RHS_PLAIN, 3,  1));
      queue_item(cmd_item(CMD_APPLY, LHS_DEREF,  RHS_DEREF, 63, 3));
      // dereference of an empty row
      queue_item(cmd_item(CMD_APPLY, LHS_DEREF,  RHS_PLAIN, 10, 1));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_DEREF, 11, 12));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_PLAIN, 0,  0));
      // unsupported kind pairs
      queue_item(cmd_item(CMD_APPLY, LHS_BAD_LO, RHS_ADDR,  1,  1));
      queue_item(cmd_item(CMD_APPLY, LHS_BAD_HI, RHS_DEREF, 2,  4));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_BAD,   3,  5));
      queue_item(cmd_item(CMD_APPLY, LHS_DEREF,  RHS_BAD,   63, 0));
      queue_item(cmd_item(CMD_APPLY, LHS_BAD_LO, RHS_BAD,   0,  63));
      queue_item(cmd_item(CMD_READ,  LHS_PLAIN,  RHS_DEREF, 63, 17));
      queue_item(cmd_item(CMD_READ,  LHS_BAD_LO, RHS_ADDR,  2,  0));
      queue_item(cmd_item(CMD_APPLY, LHS_PLAIN,  RHS_PLAIN, 62, 63));
      // self pointer: row 0 points to 0, so *0 is row 0 itself
      queue_item(cmd_item(CMD_APPLY, LHS_DEREF,  RHS_ADDR,  0,  33));
      queue_item(cmd_item(CMD_APPLY, LHS_DEREF,  RHS_DEREF, 0,  0));

      // no idling, plus a long receiver hold-off while requests keep coming
      hold_arm = 1'b1;
      queue_random(RANDOM_PER_PHASE);
      drain_all();

      // sender idles
      send_idle_pct  = 54;
      recv_stall_pct = 0;
      queue_random(RANDOM_PER_PHASE);
      drain_all();

      // receiver stalls
      send_idle_pct  = 0;
      recv_stall_pct = 54;
      queue_random(RANDOM_PER_PHASE);
      drain_all();

      // both sides idle
      send_idle_pct  = 37;
      recv_stall_pct = 37;
      queue_random(RANDOM_PER_PHASE);
      drain_all();

      // closing mix with no idling
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random(40);
      drain_all();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatches++;
         $error("%0d result items never arrived", pending_results.size());
      end
      if (mismatches == 0)
         $display("PASS points_to_constraint_step");
      else
         $display("FAIL points_to_constraint_step");
      $finish;
   end

endmodule
